// ===== design/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the command frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

   typedef enum logic [2:0] {
      PH_CMD  = 3'd0,
      PH_OPA  = 3'd1,
      PH_OPB  = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4
   } cfd_phase_type;

   localparam logic [7:0] CMD_PLAIN_LO = 8'h00;
   localparam logic [7:0] CMD_OPER_LO  = 8'h40;
   localparam logic [7:0] CMD_TOP_LO   = 8'hC0;
   localparam logic [7:0] CMD_DATA_LO  = 8'h80;
   localparam logic [7:0] CMD_DATA_HI  = 8'h82;
   localparam logic [7:0] CMD_TOP_HI   = 8'hC5;
   localparam logic [7:0] CMD_OPER_HI  = 8'h42;
   localparam logic [7:0] CMD_PLAIN_HI = 8'h03;
   localparam logic [7:0] LEN_FOUR     = 8'h03;

   localparam int FLAG_OPERANDS = 6;
   localparam int FLAG_DATA     = 7;

   typedef struct packed {
      logic [7:0] command_code;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic       has_payload;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_end;
      logic       code_known;
      logic       length_fits;
   } cfd_result_type;

endpackage

// ===== design/command_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// command_frame_deframer
// Splits a received byte stream into command frames and reports each data
// word with its frame header, index, last mark and code checks.
// ----------------------------------------------------------------------------
// One word is accepted per clock cycle when the result side keeps up. A word
// is held in the input register, and its result is formed from there and
// loaded into the result register, from which the receiver takes it. The
// throughput is set by the frame state update, which handles one word per
// cycle between the two registers. Header words that do not close a
// data-free frame give no result.
module command_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_command_code,
   output logic [7:0] rsp_operand_a,
   output logic [7:0] rsp_operand_b,
   output logic       rsp_has_payload,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic       rsp_frame_end,
   output logic       rsp_code_known,
   output logic       rsp_length_fits
);
   import cfd_pkg::*;

   logic           held_valid;
   logic [7:0]     held_byte;
   logic           out_free;
   logic           take;
   logic           emit;
   cfd_result_type result;
   cfd_result_type rsp_result;

   assign take = held_valid && out_free;

   cfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .take       (take),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   cfd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .rx_byte(held_byte),
      .emit   (emit),
      .result (result)
   );

   cfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_result(rsp_result)
   );

   assign rsp_command_code  = rsp_result.command_code;
   assign rsp_operand_a     = rsp_result.operand_a;
   assign rsp_operand_b     = rsp_result.operand_b;
   assign rsp_has_payload   = rsp_result.has_payload;
   assign rsp_payload_byte  = rsp_result.payload_byte;
   assign rsp_payload_index = rsp_result.payload_index;
   assign rsp_frame_end     = rsp_result.frame_end;
   assign rsp_code_known    = rsp_result.code_known;
   assign rsp_length_fits   = rsp_result.length_fits;

endmodule

// ===== design/cfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// cfd_in_reg
// Input register: holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module cfd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       held_valid,
   output logic [7:0] held_byte
);
   import cfd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

// ===== design/cfd_parser.sv =====
// ----------------------------------------------------------------------------
// cfd_parser
// Frame state machine: one word per step, at most one result per word.
// ----------------------------------------------------------------------------
module cfd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output logic                    emit,
   output cfd_pkg::cfd_result_type result
);
   import cfd_pkg::*;

   cfd_phase_type phase_ff, phase_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] opa_ff, opa_in;
   logic [7:0] opb_ff, opb_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] count_ff, count_in;
   logic       emit_raw;
   logic       data_word;
   logic       last_word;

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      emit_raw  = 1'b0;
      data_word = 1'b0;
      last_word = 1'b0;
      case (phase_ff)
         PH_OPA: begin
            opa_in   = rx_byte;
            phase_in = PH_OPB;
         end
         PH_OPB: begin
            opb_in = rx_byte;
            if (cmd_ff[FLAG_DATA]) begin
               phase_in = PH_LEN;
            end else begin
               phase_in  = PH_CMD;
               emit_raw  = 1'b1;
               last_word = 1'b1;
            end
         end
         PH_LEN: begin
            len_in   = rx_byte;
            count_in = 8'd0;
            phase_in = PH_DATA;
         end
         PH_DATA: begin
            emit_raw  = 1'b1;
            data_word = 1'b1;
            last_word = (count_ff == len_ff);
            if (last_word) begin
               phase_in = PH_CMD;
            end else begin
               count_in = count_ff + 8'd1;
            end
         end
         default: begin
            cmd_in   = rx_byte;
            opa_in   = 8'd0;
            opb_in   = 8'd0;
            len_in   = 8'd0;
            count_in = 8'd0;
            if (rx_byte[FLAG_OPERANDS]) begin
               phase_in = PH_OPA;
            end else if (rx_byte[FLAG_DATA]) begin
               phase_in = PH_LEN;
            end else begin
               phase_in  = PH_CMD;
               emit_raw  = 1'b1;
               last_word = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      emit                 = step && emit_raw;
      result.command_code  = cmd_in;
      result.operand_a     = opa_in;
      result.operand_b     = opb_in;
      result.has_payload   = data_word;
      result.payload_byte  = data_word ? rx_byte : 8'd0;
      result.payload_index = data_word ? count_ff : 8'd0;
      result.frame_end     = last_word;
      result.code_known    = cmd_in inside {[CMD_PLAIN_LO : CMD_PLAIN_HI],
                                            [CMD_OPER_LO : CMD_OPER_HI],
                                            [CMD_DATA_LO : CMD_DATA_HI],
                                            [CMD_TOP_LO : CMD_TOP_HI]};
      result.length_fits   = (cmd_in inside {[CMD_DATA_LO : CMD_DATA_HI]}) ?
                             (len_in == LEN_FOUR) : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CMD;
         cmd_ff   <= 8'd0;
         opa_ff   <= 8'd0;
         opb_ff   <= 8'd0;
         len_ff   <= 8'd0;
         count_ff <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         opa_ff   <= opa_in;
         opb_ff   <= opb_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      emit && result.has_payload |-> result.payload_index <= len_ff)
      else $error("Data index runs past the announced length.");

   a_header_result_ends: assert property (@(posedge clock) disable iff (reset)
      emit && !result.has_payload |-> result.frame_end)
      else $error("A data-free result does not close its frame.");

   a_last_data_returns: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_DATA && count_ff == len_ff |=> phase_ff == PH_CMD)
      else $error("Last data word did not return to command phase.");

endmodule

// ===== design/cfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module cfd_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  cfd_pkg::cfd_result_type result,
   output logic                    free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cfd_pkg::cfd_result_type rsp_result
);
   import cfd_pkg::*;

   logic           valid_ff, valid_in;
   cfd_result_type data_ff, data_in;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

endmodule
